// ===== design/apfb_pkg.sv =====
`timescale 1ns / 1ps

package apfb_pkg;

    localparam int unsigned HDR_W    = 32;
    localparam int unsigned ME_W     = 56;
    localparam int unsigned CRC_W    = 24;
    localparam int unsigned MSG_W    = HDR_W + ME_W;

    localparam logic [CRC_W-1:0] CRC_POLY = 24'hFFF409;

    // frame kinds
    localparam logic [1:0] KIND_DF17     = 2'd0;
    localparam logic [1:0] KIND_DF18     = 2'd1;
    localparam logic [1:0] KIND_DF18_ANON = 2'd2;
    localparam logic [1:0] KIND_DF18_IMF = 2'd3;

    // downlink format / capability bytes
    localparam logic [7:0] DFCA_DF17      = 8'((17 << 3) | 6);
    localparam logic [7:0] DFCA_DF18      = 8'((18 << 3) | 2);
    localparam logic [7:0] DFCA_DF18_ANON = 8'((18 << 3) | 5);

    // altitude: idx = floor((2*ft + 2025) / 50), saturated
    localparam int unsigned ALT_IDX_W   = 11;
    localparam int unsigned ALT_NUM_W   = 20;
    localparam logic [ALT_IDX_W-1:0] ALT_MAX_INDEX = 11'h7FF;
    localparam logic signed [ALT_NUM_W-1:0] ALT_OFFSET = 20'sd2025;
    localparam logic signed [ALT_NUM_W-1:0] ALT_SAT_NUM = 20'sd102400;
    // floor(m / 25) = (m * 83887) >> 21, exact for m below 91180
    localparam logic [16:0] DIV25_MUL   = 17'd83887;
    localparam int unsigned DIV25_SHIFT = 21;
    localparam logic [11:0] ALT_Q_BIT   = 12'h010;

    typedef logic [MSG_W-1:0][CRC_W-1:0] crc_matrix_t;

    // Column k: remainder left by a single one at message bit k (LSB first).
    function automatic crc_matrix_t crc_matrix();
        crc_matrix_t      mat;
        logic [CRC_W-1:0] rem;
        rem = CRC_POLY;
        for (int k = 0; k < MSG_W; k++) begin
            mat[k] = rem;
            if (rem[CRC_W-1])
                rem = (rem << 1) ^ CRC_POLY;
            else
                rem = rem << 1;
        end
        return mat;
    endfunction

    localparam crc_matrix_t CRC_COLS = crc_matrix();

endpackage

// ===== design/airborne_position_frame_builder.sv =====
`timescale 1ns / 1ps

// Airborne position frame builder: takes one position report per item and
// returns the extended squitter header word, the 56-bit ME field and the
// 24-bit Mode S parity. The block is a two-register pipeline (input register,
// result register) and accepts one item every cycle unless a stalled result
// holds while one more item waits in the input register; each item passes
// from the input register to the result register. The altitude divide by 50
// is a constant reciprocal multiply and the parity is a fixed XOR network, both
// within the single stage between the two registers.
module airborne_position_frame_builder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [23:0]         icao_address,
    input  logic [4:0]          type_code,
    input  logic signed [16:0]  altitude_feet,
    input  logic                odd_frame,
    input  logic [16:0]         cpr_latitude,
    input  logic [16:0]         cpr_longitude,
    input  logic [1:0]          frame_kind,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         header_word,
    output logic [55:0]         me_field,
    output logic [23:0]         parity
);

    logic                s1_valid_reg;
    logic                out_valid_reg;
    logic [23:0]         addr_reg;
    logic [4:0]          tc_reg;
    logic signed [16:0]  alt_reg;
    logic                odd_reg;
    logic [16:0]         lat_reg;
    logic [16:0]         lon_reg;
    logic [1:0]          kind_reg;
    logic [31:0]         header_reg;
    logic [55:0]         me_reg;
    logic [23:0]         parity_reg;

    logic                out_adv;
    logic                in_accept;
    logic                s1_move;
    logic                s1_valid_next;
    logic [31:0]         header_next;
    logic [55:0]         me_next;
    logic [23:0]         parity_next;

    logic [7:0]                                    dfca;
    logic                                          imf;
    logic signed [apfb_pkg::ALT_NUM_W-1:0]         alt_num;
    logic [15:0]                                   alt_half;
    logic [32:0]                                   alt_prod;
    logic [apfb_pkg::ALT_IDX_W-1:0]                alt_idx;
    logic [11:0]                                   alt_code;
    logic [apfb_pkg::MSG_W-1:0]                    msg;

    assign out_adv   = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || out_adv;
    assign in_accept = in_valid && in_ready;
    assign s1_move   = s1_valid_reg && out_adv;

    always_comb
    begin
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (s1_move)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_comb
    begin
        imf = 1'b0;
        case (kind_reg)
            apfb_pkg::KIND_DF17:      dfca = apfb_pkg::DFCA_DF17;
            apfb_pkg::KIND_DF18:      dfca = apfb_pkg::DFCA_DF18;
            apfb_pkg::KIND_DF18_ANON: dfca = apfb_pkg::DFCA_DF18_ANON;
            apfb_pkg::KIND_DF18_IMF:
            begin
                dfca = apfb_pkg::DFCA_DF18;
                imf  = 1'b1;
            end
            default:                  dfca = apfb_pkg::DFCA_DF18;
        endcase
    end

    // Altitude step index; halve first so the reciprocal fits 16 x 17 bits.
    always_comb
    begin
        alt_num  = {{(apfb_pkg::ALT_NUM_W-18){alt_reg[16]}}, alt_reg, 1'b0}
                 + apfb_pkg::ALT_OFFSET;
        alt_half = alt_num[16:1];
        alt_prod = {1'b0, alt_half} * {16'd0, apfb_pkg::DIV25_MUL};
        if (alt_num[apfb_pkg::ALT_NUM_W-1])
            alt_idx = '0;
        else if (alt_num >= apfb_pkg::ALT_SAT_NUM)
            alt_idx = apfb_pkg::ALT_MAX_INDEX;
        else
            alt_idx = alt_prod[apfb_pkg::DIV25_SHIFT +: apfb_pkg::ALT_IDX_W];
        alt_code = {alt_idx[10:4], 1'b0, alt_idx[3:0]} | apfb_pkg::ALT_Q_BIT;
    end

    always_comb
    begin
        header_next = {dfca, addr_reg};
        me_next     = {tc_reg, 2'b00, imf, alt_code, 1'b0, odd_reg, lat_reg, lon_reg};
        msg         = {header_next, me_next};
        parity_next = '0;
        for (int i = 0; i < apfb_pkg::MSG_W; i++) begin
            if (msg[i])
                parity_next = parity_next ^ apfb_pkg::CRC_COLS[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (out_adv)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            addr_reg <= icao_address;
            tc_reg   <= type_code;
            alt_reg  <= altitude_feet;
            odd_reg  <= odd_frame;
            lat_reg  <= cpr_latitude;
            lon_reg  <= cpr_longitude;
            kind_reg <= frame_kind;
        end
        if (s1_move)
        begin
            header_reg <= header_next;
            me_reg     <= me_next;
            parity_reg <= parity_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign header_word = header_reg;
    assign me_field    = me_reg;
    assign parity      = parity_reg;

    // A full input stage behind a stalled result must not take another item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("item taken while both stages are held");

    // A held result keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(parity_reg)
            && $stable(me_reg) && $stable(header_reg)))
        else $error("stalled result changed");

    // Q bit set, time and spare bits clear in every result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (me_reg[40] && !me_reg[35] && me_reg[50:49] == 2'b00))
        else $error("fixed ME bits wrong");

    // IMF only on DF18 with capability two.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && me_reg[48]) |-> (header_reg[31:24] == apfb_pkg::DFCA_DF18))
        else $error("IMF set on wrong frame kind");

endmodule
